// ===== sv/oace_pkg.sv =====
// Shared types and codes for the ordered array engine.
`default_nettype none

package oace_pkg;

  // request codes
  localparam logic [2:0] REQ_TRAVERSE = 3'd0;
  localparam logic [2:0] REQ_UPDATE   = 3'd1;
  localparam logic [2:0] REQ_DELETE   = 3'd2;
  localparam logic [2:0] REQ_SEARCH   = 3'd3;
  localparam logic [2:0] REQ_INSERT   = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_BAD_POS   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  localparam int POS_W = 4;
  localparam int VAL_W = 32;

  // classified request handed from front to back
  typedef struct packed {
    logic [2:0]              op;
    logic [2:0]              status;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/ordered_array_crud_engine.sv =====
// Top level of the ordered array engine: front end, command queue and back end.
`default_nettype none

// Keeps a packed array of up to DEPTH signed 32-bit words plus a fill count,
// and serves one request per input item: traverse, update, delete, search or
// insert (req_type 0..4; codes 5..7 are taken and dropped without a result).
// Each request yields one or more result items, the final one flagged by
// out_last. Traverse gives one item per valid entry, search one per match;
// every other request, and every error (empty, bad position, full, not
// found), gives exactly one item. out_fill_count is the count after the
// request. The front end checks each request against its own running count
// and queues a command (two deep), so requests keep arriving while the back
// end works. The back end owns the entry memory, which has one read and one
// write port, and that read port sets the pace. Delete and insert read every
// moved entry once (an insert at the append point moves nothing and reads
// none). A stalled output holds its item while the back end waits; the
// result register frees the back end as soon as the item is taken.
// No clearing pass is needed after reset: entries at or above the count are
// never read.

module ordered_array_crud_engine import oace_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [2:0]              in_req_type,
  input  wire logic [POS_W-1:0]        in_position,
  input  wire logic signed [VAL_W-1:0] in_value,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [VAL_W-1:0]      out_value,
  output logic [POS_W-1:0]             out_index,
  output logic [2:0]                   out_status,
  output logic [4:0]                   out_fill_count,
  output logic                         out_last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = $bits(cmd_t) + CW;

  // front -> queue
  logic          f_push;
  cmd_t          f_cmd;
  logic [CW-1:0] f_fill;
  logic          q_full;

  // queue -> back
  logic          q_not_empty;
  logic          q_pop;
  logic [DW-1:0] q_data;
  cmd_t          b_cmd;
  logic [CW-1:0] b_fill;

  oace_front #(
    .DEPTH(DEPTH),
    .CW   (CW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req_type(in_req_type),
    .in_position(in_position),
    .in_value   (in_value),
    .q_full     (q_full),
    .q_push     (f_push),
    .q_cmd      (f_cmd),
    .q_fill     (f_fill)
  );

  oace_fifo #(
    .DW(DW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .push_data({f_cmd, f_fill}),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_not_empty),
    .pop_data (q_data)
  );

  assign b_cmd  = q_data[DW-1:CW];
  assign b_fill = q_data[CW-1:0];

  oace_back #(
    .DEPTH(DEPTH),
    .CW   (CW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_not_empty),
    .q_cmd         (b_cmd),
    .q_fill        (b_fill),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_index     (out_index),
    .out_status    (out_status),
    .out_fill_count(out_fill_count),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

// ===== sv/oace_fifo.sv =====
// Two-entry command queue between front and back.
`default_nettype none

module oace_fifo #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output logic [DW-1:0]      pop_data
);

  logic [DW-1:0] slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/oace_front.sv =====
// Front end: accepts requests, checks them against the running count, queues commands.
`default_nettype none

module oace_front import oace_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [2:0]              in_req_type,
  input  wire logic [POS_W-1:0]        in_position,
  input  wire logic signed [VAL_W-1:0] in_value,
  input  wire logic                    q_full,
  output logic                         q_push,
  output cmd_t                         q_cmd,
  output logic [CW-1:0]                q_fill
);

  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] posx, cntx;
  logic          keep;
  logic          accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign posx     = PW'(in_position);
  assign cntx     = PW'(count_r);

  always_comb begin
    q_cmd.op     = in_req_type;
    q_cmd.status = ST_OK;
    q_cmd.pos    = in_position;
    q_cmd.value  = in_value;
    q_fill       = count_r;
    keep         = 1'b1;
    case (in_req_type)
      REQ_TRAVERSE: begin
        if (count_r == '0) begin
          q_cmd.status = ST_EMPTY;
          q_cmd.value  = '0;
          q_cmd.pos    = '0;
        end
      end
      REQ_UPDATE: begin
        if (count_r == '0) begin
          q_cmd.status = ST_EMPTY;
        end else if (posx >= cntx) begin
          q_cmd.status = ST_BAD_POS;
        end
      end
      REQ_DELETE: begin
        if (count_r == '0) begin
          q_cmd.status = ST_EMPTY;
        end else if (posx >= cntx) begin
          q_cmd.status = ST_BAD_POS;
        end else begin
          q_fill = count_r - 1'b1;
        end
      end
      REQ_SEARCH: begin
        if (count_r == '0) begin
          q_cmd.status = ST_EMPTY;
          q_cmd.pos    = '0;
        end
      end
      REQ_INSERT: begin
        if (count_r == CW'(DEPTH)) begin
          q_cmd.status = ST_FULL;
        end else if (posx > cntx) begin
          q_cmd.status = ST_BAD_POS;
        end else begin
          q_fill = count_r + 1'b1;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push    = accept && keep;
  assign count_nxt = q_push ? q_fill : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/oace_back.sv =====
// Back end: entry memory, read/shift sequencer and result register.
`default_nettype none

module oace_back import oace_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int CW    = $clog2(DEPTH + 1),
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire cmd_t                q_cmd,
  input  wire logic [CW-1:0]       q_fill,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [VAL_W-1:0]  out_value,
  output logic [POS_W-1:0]         out_index,
  output logic [2:0]               out_status,
  output logic [4:0]               out_fill_count,
  output logic                     out_last
);

  localparam int PW = (CW > POS_W) ? CW : POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic signed [VAL_W-1:0] mem_r [DEPTH];

  logic [1:0]              state_r, state_nxt;
  cmd_t                    cur_r, cur_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic [AW-1:0]           rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]           left_r, left_nxt;
  logic                    pend_r, pend_nxt;
  logic [AW-1:0]           pend_idx_r, pend_idx_nxt;
  logic                    hold_r, hold_nxt;
  logic [AW-1:0]           hold_idx_r, hold_idx_nxt;
  logic signed [VAL_W-1:0] removed_r, removed_nxt;
  logic signed [VAL_W-1:0] rdata_r;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r;
  logic [POS_W-1:0]        out_index_r;
  logic [2:0]              out_status_r;
  logic [4:0]              out_fill_r;
  logic                    out_last_r;

  logic                    out_free;
  logic                    re, we, consume, match;
  logic [AW-1:0]           waddr;
  logic signed [VAL_W-1:0] wdata;
  logic                    emit;
  logic signed [VAL_W-1:0] e_value;
  logic [POS_W-1:0]        e_index;
  logic [2:0]              e_status;
  logic                    e_last;

  assign out_free = !out_valid_r || !out_stall;
  assign match    = (rdata_r == cur_r.value);

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    fill_nxt     = fill_r;
    rd_addr_nxt  = rd_addr_r;
    left_nxt     = left_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    hold_nxt     = hold_r;
    hold_idx_nxt = hold_idx_r;
    removed_nxt  = removed_r;
    q_pop        = 1'b0;
    re           = 1'b0;
    we           = 1'b0;
    waddr        = pend_idx_r;
    wdata        = rdata_r;
    consume      = 1'b0;
    emit         = 1'b0;
    e_value      = cur_r.value;
    e_index      = cur_r.pos;
    e_status     = cur_r.status;
    e_last       = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cur_nxt  = q_cmd;
          fill_nxt = q_fill;
          pend_nxt = 1'b0;
          hold_nxt = 1'b0;
          state_nxt = S_RUN;
          if (q_cmd.status != ST_OK) begin
            state_nxt = S_FIN;
          end else begin
            case (q_cmd.op)
              REQ_TRAVERSE, REQ_SEARCH: begin
                rd_addr_nxt = '0;
                left_nxt    = q_fill;
              end
              REQ_DELETE: begin
                rd_addr_nxt = AW'(q_cmd.pos);
                left_nxt    = CW'(PW'(q_fill) + PW'(1) - PW'(q_cmd.pos));
              end
              REQ_INSERT: begin
                // walk from the top entry down to the insert point
                rd_addr_nxt = AW'(q_fill - CW'(2));
                left_nxt    = CW'(PW'(q_fill) - PW'(1) - PW'(q_cmd.pos));
                if (PW'(q_fill) - PW'(1) == PW'(q_cmd.pos)) begin
                  state_nxt = S_FIN;
                end
              end
              default: begin
                state_nxt = S_FIN;
              end
            endcase
          end
        end
      end
      S_RUN: begin
        if (!pend_r && left_r == '0) begin
          state_nxt = (cur_r.op == REQ_TRAVERSE) ? S_IDLE : S_FIN;
        end else begin
          if (pend_r) begin
            consume = (cur_r.op == REQ_TRAVERSE || cur_r.op == REQ_SEARCH) ? out_free : 1'b1;
          end
          if (consume) begin
            case (cur_r.op)
              REQ_TRAVERSE: begin
                emit     = 1'b1;
                e_value  = rdata_r;
                e_index  = POS_W'(pend_idx_r);
                e_status = ST_OK;
                e_last   = (left_r == '0);
              end
              REQ_SEARCH: begin
                // a match is held back until the next one shows it is not the last
                if (match) begin
                  if (hold_r) begin
                    emit     = 1'b1;
                    e_index  = POS_W'(hold_idx_r);
                    e_status = ST_OK;
                    e_last   = 1'b0;
                  end
                  hold_nxt     = 1'b1;
                  hold_idx_nxt = pend_idx_r;
                end
              end
              REQ_DELETE: begin
                if (pend_idx_r == AW'(cur_r.pos)) begin
                  removed_nxt = rdata_r;
                end else begin
                  we    = 1'b1;
                  waddr = AW'(pend_idx_r - 1'b1);
                end
              end
              REQ_INSERT: begin
                we    = 1'b1;
                waddr = AW'(pend_idx_r + 1'b1);
              end
              default: begin
              end
            endcase
          end
          if (left_r != '0 && (!pend_r || consume)) begin
            re           = 1'b1;
            pend_nxt     = 1'b1;
            pend_idx_nxt = rd_addr_r;
            rd_addr_nxt  = (cur_r.op == REQ_INSERT) ? AW'(rd_addr_r - 1'b1)
                                                    : AW'(rd_addr_r + 1'b1);
            left_nxt     = left_r - 1'b1;
          end else if (consume) begin
            pend_nxt = 1'b0;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (cur_r.status == ST_OK) begin
            case (cur_r.op)
              REQ_SEARCH: begin
                if (hold_r) begin
                  e_index = POS_W'(hold_idx_r);
                end else begin
                  e_index  = '0;
                  e_status = ST_NOT_FOUND;
                end
              end
              REQ_DELETE: begin
                e_value = removed_r;
              end
              REQ_UPDATE, REQ_INSERT: begin
                we    = 1'b1;
                waddr = AW'(cur_r.pos);
                wdata = cur_r.value;
              end
              default: begin
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      hold_r      <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      hold_r      <= hold_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    fill_r     <= fill_nxt;
    rd_addr_r  <= rd_addr_nxt;
    pend_idx_r <= pend_idx_nxt;
    hold_idx_r <= hold_idx_nxt;
    removed_r  <= removed_nxt;
    if (emit) begin
      out_value_r  <= e_value;
      out_index_r  <= e_index;
      out_status_r <= e_status;
      out_fill_r   <= 5'(fill_r);
      out_last_r   <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[rd_addr_r];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_index      = out_index_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

// ===== sv/oace_checker.sv =====
// Port-level checks for the ordered array engine, bound to the top level.
`default_nettype none

module oace_checker import oace_pkg::*; #(
  parameter int DEPTH = 16
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic signed [VAL_W-1:0] out_value,
  input wire logic [POS_W-1:0]        out_index,
  input wire logic [2:0]              out_status,
  input wire logic [4:0]              out_fill_count,
  input wire logic                    out_last
);

  // a stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_index)
      && $stable(out_status) && $stable(out_last))
    else $error("stalled result changed");

  // error results always close their request
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last)
    else $error("error result without last");

  // fill count never exceeds the array depth
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (DEPTH > 31) || (out_fill_count <= 5'(DEPTH)))
    else $error("fill count above depth");

  // reset empties the result register
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ordered_array_crud_engine oace_checker #(.DEPTH(DEPTH)) u_oace_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_value     (out_value),
  .out_index     (out_index),
  .out_status    (out_status),
  .out_fill_count(out_fill_count),
  .out_last      (out_last)
);

`default_nettype wire
